@@ rtl/core/sta_pkg.sv @@
// Shared types and constants of the symmetric triplet assembly block.
// Used by sta_ctrl, sta_datapath, the top level and its checker.
package sta_pkg;

  localparam int MAX_NODES = 4;
  localparam int MAX_DOF   = 2;
  localparam int NODE_BITS = 20;

  localparam int NODE_IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int DOF_IDX_W  = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;

  localparam int ACT_W     = 2;
  localparam int TAB_AW    = 6;
  localparam int TAB_DEPTH = 1 << TAB_AW;
  localparam int WORD_W    = 64;
  localparam int RC_W      = 21;
  localparam int SLOT_W    = 32;
  localparam int NCNT_W    = 3;
  localparam int DCNT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOF_PER_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_ENABLE  = 2'd2;

  localparam logic [WORD_W-1:0] TINY_BITS = 64'h3D71_9799_812D_EA11;
  localparam logic [WORD_W-1:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_WR_STIFF = 2'd0,
    ACT_WR_MASS  = 2'd1,
    ACT_ASSEMBLE = 2'd2,
    ACT_RESTART  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic wr_stiff;
    logic wr_mass;
    logic clear_counts;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic final_step;
  } ctrl_status_t;

endpackage

@@ rtl/core/sta_ctrl.sv @@
// Controller FSM of the symmetric triplet assembly block.
// Depends on sta_pkg; drives commands into sta_datapath.
module sta_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sta_pkg::ACT_W-1:0] action,
  input  sta_pkg::ctrl_status_t     status,
  output logic                      busy,
  output sta_pkg::ctrl_cmd_t        cmd
);

  sta_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      sta_pkg::ST_IDLE: begin
        if (start) begin
          unique case (sta_pkg::action_t'(action))
            sta_pkg::ACT_WR_STIFF: cmd.wr_stiff     = 1'b1;
            sta_pkg::ACT_WR_MASS:  cmd.wr_mass      = 1'b1;
            sta_pkg::ACT_RESTART:  cmd.clear_counts = 1'b1;
            sta_pkg::ACT_ASSEMBLE: begin
              // zero nodes or zero dof: nothing to emit
              if (!status.empty) begin
                cmd.load   = 1'b1;
                state_next = sta_pkg::ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      sta_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (status.final_step) state_next = sta_pkg::ST_DRAIN;
      end
      sta_pkg::ST_DRAIN: begin
        state_next = sta_pkg::ST_IDLE;
      end
      default: begin
        state_next = sta_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != sta_pkg::ST_IDLE);

endmodule

@@ rtl/core/sta_datapath.sv @@
// Datapath: config registers, element tables, index sequencer,
// two-stage read pipeline, mass filter and slot counters. Depends on sta_pkg.
module sta_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sta_pkg::ctrl_cmd_t            cmd,
  output sta_pkg::ctrl_status_t         status,
  input  logic                          wr_en,
  input  logic [sta_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [sta_pkg::CFG_W-1:0]     wr_data,
  input  logic [sta_pkg::TAB_AW-1:0]    table_index,
  input  logic [sta_pkg::WORD_W-1:0]    table_value,
  input  logic [sta_pkg::NODE_BITS-1:0] node_0,
  input  logic [sta_pkg::NODE_BITS-1:0] node_1,
  input  logic [sta_pkg::NODE_BITS-1:0] node_2,
  input  logic [sta_pkg::NODE_BITS-1:0] node_3,
  output logic                          strobe,
  output logic [sta_pkg::RC_W-1:0]      global_row,
  output logic [sta_pkg::RC_W-1:0]      global_col,
  output logic [sta_pkg::WORD_W-1:0]    stiff_word,
  output logic [sta_pkg::SLOT_W-1:0]    stiff_slot,
  output logic                          mass_present,
  output logic [sta_pkg::WORD_W-1:0]    mass_word,
  output logic [sta_pkg::SLOT_W-1:0]    mass_slot,
  output logic                          last
);

  // config registers
  logic [sta_pkg::NCNT_W-1:0] node_count;
  logic [sta_pkg::DCNT_W-1:0] dof_per_node;
  logic                       mass_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= sta_pkg::NCNT_W'(sta_pkg::MAX_NODES);
      dof_per_node <= sta_pkg::DCNT_W'(sta_pkg::MAX_DOF);
      mass_enable  <= 1'b0;
    end else if (wr_en) begin
      if (wr_index == sta_pkg::REG_NODE_COUNT)   node_count   <= wr_data[sta_pkg::NCNT_W-1:0];
      if (wr_index == sta_pkg::REG_DOF_PER_NODE) dof_per_node <= wr_data[sta_pkg::DCNT_W-1:0];
      if (wr_index == sta_pkg::REG_MASS_ENABLE)  mass_enable  <= wr_data[0];
    end
  end

  // saturated counts
  logic [sta_pkg::NCNT_W-1:0]    nn;
  logic [sta_pkg::DCNT_W-1:0]    nd;
  logic [3:0]                    edof;
  logic [sta_pkg::NODE_IDX_W-1:0] last_node;
  logic [sta_pkg::DOF_IDX_W-1:0]  last_dof;

  assign nn = (node_count > sta_pkg::NCNT_W'(sta_pkg::MAX_NODES)) ?
              sta_pkg::NCNT_W'(sta_pkg::MAX_NODES) : node_count;
  assign nd = (dof_per_node > sta_pkg::DCNT_W'(sta_pkg::MAX_DOF)) ?
              sta_pkg::DCNT_W'(sta_pkg::MAX_DOF) : dof_per_node;
  assign edof      = 4'(nn) * 4'(nd);
  assign last_node = sta_pkg::NODE_IDX_W'(nn - 3'd1);
  assign last_dof  = sta_pkg::DOF_IDX_W'(nd - 2'd1);

  // latched node numbers and sequencer counters
  logic [sta_pkg::NODE_BITS-1:0]  nodes [sta_pkg::MAX_NODES];
  logic [sta_pkg::NODE_IDX_W-1:0] ci, cj;
  logic [sta_pkg::DOF_IDX_W-1:0]  cn, cm;
  logic                           diag;

  assign diag = (ci == cj);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nodes[0] <= node_0;
      nodes[1] <= node_1;
      nodes[2] <= node_2;
      nodes[3] <= node_3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
      cn <= '0;
      cm <= '0;
    end else if (cmd.load) begin
      ci <= '0;
      cj <= '0;
      cn <= '0;
      cm <= '0;
    end else if (cmd.step) begin
      priority if (cm != last_dof) begin
        cm <= cm + 1'b1;
      end else if (cn != last_dof) begin
        cn <= cn + 1'b1;
        cm <= diag ? cn + 1'b1 : '0;   // diagonal block: upper triangle only
      end else if (cj != last_node) begin
        cj <= cj + 1'b1;
        cn <= '0;
        cm <= '0;
      end else begin
        ci <= ci + 1'b1;
        cj <= ci + 1'b1;
        cn <= '0;
        cm <= '0;
      end
    end
  end

  assign status.empty      = (nn == '0) || (nd == '0);
  assign status.final_step = (ci == last_node) && (cj == last_node) &&
                             (cn == last_dof) && (cm == last_dof);

  // pair ordering and address generation
  logic [sta_pkg::NODE_IDX_W-1:0] p, q;
  logic [7:0]                     rn, cmo, tsum;
  logic [sta_pkg::TAB_AW-1:0]     taddr;
  logic [sta_pkg::RC_W-1:0]       row, col;

  always_comb begin
    p     = (nodes[ci] <= nodes[cj]) ? ci : cj;
    q     = (p == ci) ? cj : ci;
    rn    = 8'(nd) * 8'(p);
    cmo   = 8'(nd) * 8'(q);
    tsum  = 8'(8'(edof) * (8'(cn) + rn)) + 8'(cm) + cmo;
    taddr = tsum[sta_pkg::TAB_AW-1:0];
    row   = sta_pkg::RC_W'(nodes[p]) * sta_pkg::RC_W'(nd) + sta_pkg::RC_W'(cn);
    col   = sta_pkg::RC_W'(nodes[q]) * sta_pkg::RC_W'(nd) + sta_pkg::RC_W'(cm);
  end

  // element tables, registered read
  logic [sta_pkg::WORD_W-1:0] stiff_mem [sta_pkg::TAB_DEPTH];
  logic [sta_pkg::WORD_W-1:0] mass_mem  [sta_pkg::TAB_DEPTH];
  logic [sta_pkg::WORD_W-1:0] stiff_rd, mass_rd;

  always_ff @(posedge clk) begin
    if (cmd.wr_stiff) stiff_mem[table_index] <= table_value;
    if (cmd.wr_mass)  mass_mem[table_index]  <= table_value;
    stiff_rd <= stiff_mem[taddr];
    mass_rd  <= mass_mem[taddr];
  end

  // stage 1: metadata alongside the table read
  logic                     s1_valid, s1_last;
  logic [sta_pkg::RC_W-1:0] s1_row, s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    s1_row  <= row;
    s1_col  <= col;
    s1_last <= status.final_step;
  end

  // mass filter and slot counters
  logic                       mass_hit;
  logic [sta_pkg::SLOT_W-1:0] stiff_count, mass_count;

  assign mass_hit = mass_enable && ((mass_rd & sta_pkg::MAG_MASK) > sta_pkg::TINY_BITS);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_counts) begin
      stiff_count <= '0;
      mass_count  <= '0;
    end else if (s1_valid) begin
      stiff_count <= stiff_count + 1'b1;
      if (mass_hit) mass_count <= mass_count + 1'b1;
    end
  end

  // stage 2: output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    global_row   <= s1_row;
    global_col   <= s1_col;
    stiff_word   <= stiff_rd;
    stiff_slot   <= stiff_count;
    mass_present <= mass_hit;
    mass_word    <= mass_hit ? mass_rd : '0;
    mass_slot    <= mass_hit ? mass_count : '0;
    last         <= s1_last;
  end

endmodule

@@ rtl/core/symmetric_triplet_assembly.sv @@
// Top level of the symmetric triplet assembly block.
// Depends on sta_pkg, sta_ctrl and sta_datapath.
//
//   channel   handshake            payload
//   --------  -------------------  ----------------------------------------------
//   command   start high, busy low action, table_index, table_value, node_0..3
//   result    strobe, one cycle    global_row, global_col, stiff_word, stiff_slot,
//                                  mass_present, mass_word, mass_slot, last
//   config    wr_en                wr_index, wr_data
//
// Table writes and slot restarts are accepted in IDLE, leave busy low and give no result.
// An assemble of K triplets, K = nn*nd*(nn*nd+1)/2 (36 at four nodes, two dof),
// holds busy through RUN and DRAIN; the sequencer issues one table read per cycle in RUN.
// Each triplet passes the stage-1 table read and the stage-2 output registers; results strobe one per cycle.
// Reset is synchronous: slot counts clear, registers go to 4, 2 and 0; tables
// hold nothing until written. The receiver cannot stall the result stream.
module symmetric_triplet_assembly (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [sta_pkg::ACT_W-1:0]     action,
  input  logic [sta_pkg::TAB_AW-1:0]    table_index,
  input  logic [sta_pkg::WORD_W-1:0]    table_value,
  input  logic [sta_pkg::NODE_BITS-1:0] node_0,
  input  logic [sta_pkg::NODE_BITS-1:0] node_1,
  input  logic [sta_pkg::NODE_BITS-1:0] node_2,
  input  logic [sta_pkg::NODE_BITS-1:0] node_3,
  // configuration port
  input  logic                          wr_en,
  input  logic [sta_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [sta_pkg::CFG_W-1:0]     wr_data,
  // result channel
  output logic                          strobe,
  output logic [sta_pkg::RC_W-1:0]      global_row,
  output logic [sta_pkg::RC_W-1:0]      global_col,
  output logic [sta_pkg::WORD_W-1:0]    stiff_word,
  output logic [sta_pkg::SLOT_W-1:0]    stiff_slot,
  output logic                          mass_present,
  output logic [sta_pkg::WORD_W-1:0]    mass_word,
  output logic [sta_pkg::SLOT_W-1:0]    mass_slot,
  output logic                          last
);

  sta_pkg::ctrl_cmd_t    cmd;
  sta_pkg::ctrl_status_t status;

  // controller: accepts transfers, walks the element through RUN, drains
  sta_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // datapath: tables, index walk, read pipeline, mass filter, slot counts
  sta_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .table_index  (table_index),
    .table_value  (table_value),
    .node_0       (node_0),
    .node_1       (node_1),
    .node_2       (node_2),
    .node_3       (node_3),
    .strobe       (strobe),
    .global_row   (global_row),
    .global_col   (global_col),
    .stiff_word   (stiff_word),
    .stiff_slot   (stiff_slot),
    .mass_present (mass_present),
    .mass_word    (mass_word),
    .mass_slot    (mass_slot),
    .last         (last)
  );

endmodule

@@ rtl/core/sta_checker.sv @@
// Port-level checker for symmetric_triplet_assembly, bound to the top level.
// Depends on sta_pkg for field widths.
module sta_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        strobe,
  input logic                        mass_present,
  input logic [sta_pkg::WORD_W-1:0]  mass_word,
  input logic [sta_pkg::SLOT_W-1:0]  mass_slot,
  input logic                        last
);

  // an element's triplets come out in one unbroken run
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside an element's triplet run");

  // final triplet closes the run
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result after the final triplet");

  // more triplets pending means the block is still busy
  a_busy_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("busy dropped before the element finished");

  // a filtered mass entry reports zeros
  a_mass_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !mass_present |-> (mass_word == '0) && (mass_slot == '0))
    else $error("mass fields set without a mass triplet");

endmodule

bind symmetric_triplet_assembly sta_checker u_sta_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .strobe       (strobe),
  .mass_present (mass_present),
  .mass_word    (mass_word),
  .mass_slot    (mass_slot),
  .last         (last)
);
